### hw/rtl/sitoa_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds the shared constants, the sequencer state type and the character transaction type.
// No dependencies.
package sitoa_pkg;

	// Default width of the signed input value
	localparam int VALUE_BITS_DEF = 32;

	// Magnitude bits folded into the BCD register per conversion cycle
	localparam int STEP_BITS = 4;

	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	// One output character on its way to the output register
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_t;

endpackage

### hw/rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitoa_pkg, sitoa_dabble and sitoa_out_reg.
//
// Usage:
//   Input channel (in_valid / in_stall / value) takes one signed two's complement
//   integer per transaction. in_stall is high from the cycle after acceptance until the
//   last character of that value has been handed to the output register.
//   Output channel (out_valid / out_stall / character / last_char) returns the decimal
//   text one character per transaction, most significant first: an optional '-', then
//   the digits without leading zeros ("0" for zero). last_char marks the final one.
// Sequence:
//   After acceptance the magnitude is converted to BCD by the shift-and-add-3 unit,
//   four bits a cycle. Then the sign is emitted if the value is negative, and each BCD
//   digit position is visited in turn (leading zeros are dropped without output).
// Reset: arst_n clears the sequencer to idle and empties the output register.
// Stall: when out_stall holds the output register full, the sequencer waits on the
//   character it is about to emit; no character is lost or repeated.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            character,
	output logic                  last_char
);

	// Decimal digits that cover any magnitude up to 2^VALUE_BITS - 1
	localparam int NUM_DIGITS = (VALUE_BITS * 302) / 1000 + 1;
	localparam int BCD_BITS   = NUM_DIGITS * 4;
	localparam int ITERS      = (VALUE_BITS + sitoa_pkg::STEP_BITS - 1) / sitoa_pkg::STEP_BITS;
	localparam int PAD_BITS   = ITERS * sitoa_pkg::STEP_BITS;
	localparam int CNT_MAX    = (ITERS > NUM_DIGITS) ? ITERS : NUM_DIGITS;
	localparam int CNT_BITS   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

	sitoa_pkg::state_t state_q, state_next;

	logic [PAD_BITS-1:0] mag_q;
	logic [BCD_BITS-1:0] bcd_q;
	logic [BCD_BITS-1:0] bcd_step;
	logic [CNT_BITS-1:0] cnt_q;
	logic                neg_q;
	logic                started_q;

	logic                in_accept;
	logic [VALUE_BITS-1:0] mag_abs;
	logic [3:0]          top_digit;
	logic                conv_done;
	logic                digit_is_last;
	logic                digit_emit;
	logic                emit_ready;
	logic                push;
	sitoa_pkg::char_t    push_data;
	logic                digit_advance;

	// Magnitude: the most negative value negates to itself, which read unsigned is 2^(N-1)
	assign mag_abs = value[VALUE_BITS-1] ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;

	assign in_accept     = in_valid && !in_stall;
	assign top_digit     = bcd_q[BCD_BITS-1 -: 4];
	assign conv_done     = (cnt_q == CNT_BITS'(ITERS - 1));
	assign digit_is_last = (cnt_q == CNT_BITS'(NUM_DIGITS - 1));
	// Drop leading zeros, but always emit the units digit
	assign digit_emit    = started_q || (top_digit != 4'd0) || digit_is_last;

	sitoa_dabble #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_dabble (
		.bcd_in  (bcd_q),
		.bits_in (mag_q[PAD_BITS-1 -: sitoa_pkg::STEP_BITS]),
		.bcd_out (bcd_step)
	);

	sitoa_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.ready     (emit_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last_char (last_char)
	);

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			sitoa_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_next = sitoa_pkg::ST_CONV;
				end
			end
			sitoa_pkg::ST_CONV: begin
				if (conv_done) begin
					state_next = neg_q ? sitoa_pkg::ST_SIGN : sitoa_pkg::ST_DIGITS;
				end
			end
			sitoa_pkg::ST_SIGN: begin
				if (emit_ready) begin
					state_next = sitoa_pkg::ST_DIGITS;
				end
			end
			sitoa_pkg::ST_DIGITS: begin
				if (digit_advance && digit_is_last) begin
					state_next = sitoa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = sitoa_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall       = 1'b1;
		push           = 1'b0;
		push_data.code = sitoa_pkg::CHAR_ZERO + {4'd0, top_digit};
		push_data.last = digit_is_last;
		digit_advance  = 1'b0;
		case (state_q)
			sitoa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			sitoa_pkg::ST_CONV: begin
				in_stall = 1'b1;
			end
			sitoa_pkg::ST_SIGN: begin
				push           = emit_ready;
				push_data.code = sitoa_pkg::CHAR_MINUS;
				push_data.last = 1'b0;
			end
			sitoa_pkg::ST_DIGITS: begin
				// hold on a digit to emit until the output register frees up
				push          = digit_emit && emit_ready;
				digit_advance = !digit_emit || emit_ready;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sitoa_pkg::ST_IDLE;
			cnt_q     <= '0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_next;
			case (state_q)
				sitoa_pkg::ST_IDLE: begin
					if (in_accept) begin
						cnt_q     <= '0;
						started_q <= 1'b0;
					end
				end
				sitoa_pkg::ST_CONV: begin
					// reuse the counter for digit positions once conversion ends
					cnt_q <= conv_done ? '0 : cnt_q + 1'b1;
				end
				sitoa_pkg::ST_DIGITS: begin
					if (digit_advance) begin
						cnt_q     <= cnt_q + 1'b1;
						started_q <= started_q || digit_emit;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			sitoa_pkg::ST_IDLE: begin
				if (in_accept) begin
					neg_q <= value[VALUE_BITS-1];
					mag_q <= PAD_BITS'(mag_abs);
					bcd_q <= '0;
				end
			end
			sitoa_pkg::ST_CONV: begin
				bcd_q <= bcd_step;
				mag_q <= mag_q << sitoa_pkg::STEP_BITS;
			end
			sitoa_pkg::ST_DIGITS: begin
				if (digit_advance) begin
					bcd_q <= {bcd_q[BCD_BITS-5:0], 4'd0};
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	// Never push into a full output register that is being held
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> emit_ready)
		else $error("character pushed while output register is blocked");

	// An accepted value always starts the conversion phase
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == sitoa_pkg::ST_CONV))
		else $error("accepted value did not start conversion");

	// Every digit position read out after conversion is a valid BCD digit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sitoa_pkg::ST_DIGITS) |-> (top_digit <= 4'd9))
		else $error("BCD digit out of range");

	// The final character closes the value and frees the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.last) |=> (state_q == sitoa_pkg::ST_IDLE && !in_stall))
		else $error("sequencer not idle after final character");

endmodule

### hw/rtl/sitoa_dabble.sv
// Shift-and-add-3 unit of the converter: folds STEP_BITS magnitude bits into a BCD word.
// Depends on sitoa_pkg.
module sitoa_dabble #(
	parameter int NUM_DIGITS = 10
) (
	input  logic [NUM_DIGITS*4-1:0]          bcd_in,
	input  logic [sitoa_pkg::STEP_BITS-1:0]  bits_in,
	output logic [NUM_DIGITS*4-1:0]          bcd_out
);

	localparam int BCD_BITS = NUM_DIGITS * 4;

	always_comb begin
		logic [BCD_BITS-1:0] bcd_v;
		bcd_v = bcd_in;
		for (int s = 0; s < sitoa_pkg::STEP_BITS; s++) begin
			// correct every digit that would overflow on the next doubling
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (bcd_v[d*4 +: 4] >= 4'd5) begin
					bcd_v[d*4 +: 4] = bcd_v[d*4 +: 4] + 4'd3;
				end
			end
			bcd_v = {bcd_v[BCD_BITS-2:0], bits_in[sitoa_pkg::STEP_BITS-1-s]};
		end
		bcd_out = bcd_v;
	end

endmodule

### hw/rtl/sitoa_out_reg.sv
// Output register of the converter: holds one character transaction until the receiver takes it.
// Depends on sitoa_pkg.
module sitoa_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sitoa_pkg::char_t  push_data,
	output logic              ready,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        character,
	output logic              last_char
);

	logic             valid_q;
	sitoa_pkg::char_t data_q;

	// free when empty or when the held transaction leaves this cycle
	assign ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && push) begin
			data_q <= push_data;
		end
	end

	assign out_valid = valid_q;
	assign character = data_q.code;
	assign last_char = data_q.last;

endmodule
